/* hdl/sqw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_pkg
// Shared types and constants for the square-wave channel with period sweep.
// ----------------------------------------------------------------------------
package sqw_pkg;

    localparam int unsigned DEF_LENGTH_LIMIT = 64;

    localparam int unsigned PERIOD_W   = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'h7FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWEEP    = 3'd0,
        CFG_DUTY_LEN = 3'd1,
        CFG_ENVELOPE = 3'd2,
        CFG_PERIOD   = 3'd3,
        CFG_LEN_EN   = 3'd4,
        CFG_MASTER   = 3'd5
    } t_cfg_idx;

    // duty patterns, bit n is the level at duty position n
    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h7F, 8'h7E, 8'h1E, 8'h81};

    typedef struct packed {
        logic div_tap_bit;
        logic trigger;
    } t_in_word;

    typedef struct packed {
        logic [3:0]          level;
        logic                channel_active;
        logic [PERIOD_W-1:0] current_period;
    } t_out_word;

    typedef struct packed {
        logic [6:0]          sweep_setting;
        logic [7:0]          duty_and_length;
        logic [7:0]          envelope_setting;
        logic [PERIOD_W-1:0] initial_period;
        logic                length_enable;
        logic                master_enable;
    } t_cfg;

endpackage

/* hdl/sqw_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_core
// Channel state: frame sequencer, length, envelope, sweep, period and duty.
// Advances one step per accepted word and gives that step's result.
// ----------------------------------------------------------------------------
module sqw_core import sqw_pkg::*; #(
    parameter int unsigned LENGTH_LIMIT = DEF_LENGTH_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    localparam int unsigned LC_MAX = ((LENGTH_LIMIT + 1) > 63) ? (LENGTH_LIMIT + 1) : 63;
    localparam int unsigned LC_W   = $clog2(LC_MAX + 1);
    localparam logic [LC_W-1:0] LIMIT = LC_W'(LENGTH_LIMIT);

    logic                r_prev_tap, n_prev_tap;
    logic [2:0]          r_frame, n_frame;
    logic                r_active, n_active;
    logic [LC_W-1:0]     r_len, n_len;
    logic [3:0]          r_vol, n_vol;
    logic                r_env_up, n_env_up;
    logic [2:0]          r_env_pace, n_env_pace;
    logic [2:0]          r_env_cnt, n_env_cnt;
    logic [2:0]          r_sw_pace, n_sw_pace;
    logic                r_sw_sub, n_sw_sub;
    logic [2:0]          r_sw_shift, n_sw_shift;
    logic [2:0]          r_sw_cnt, n_sw_cnt;
    logic [PERIOD_W-1:0] r_shadow, n_shadow;
    logic [PERIOD_W:0]   r_pcnt, n_pcnt;
    logic [2:0]          r_duty, n_duty;
    logic [1:0]          r_phase, n_phase;

    logic                tap_fall;
    logic                dac_on;
    logic                run;
    logic [PERIOD_W:0]   start_sum;
    logic [PERIOD_W-1:0] sw_diff;
    logic [PERIOD_W:0]   sw_sum;
    logic [PERIOD_W:0]   pc_inc;
    logic [3:0]          level;

    always_comb begin
        tap_fall   = r_prev_tap & ~i_word.div_tap_bit;
        dac_on     = |i_cfg.envelope_setting[7:3];
        n_prev_tap = i_word.div_tap_bit;
        n_frame    = tap_fall ? r_frame + 3'd1 : r_frame;
        n_active   = r_active & dac_on;
        n_len      = r_len;
        n_vol      = r_vol;
        n_env_up   = r_env_up;
        n_env_pace = r_env_pace;
        n_env_cnt  = r_env_cnt;
        n_sw_pace  = r_sw_pace;
        n_sw_sub   = r_sw_sub;
        n_sw_shift = r_sw_shift;
        n_sw_cnt   = r_sw_cnt;
        n_shadow   = r_shadow;
        n_pcnt     = r_pcnt;
        n_duty     = r_duty;
        n_phase    = r_phase;
        start_sum  = {1'b0, i_cfg.initial_period}
                   + {1'b0, i_cfg.initial_period >> i_cfg.sweep_setting[2:0]};

        // trigger: reload settings
        if (i_word.trigger && dac_on && i_cfg.master_enable) begin
            n_active   = 1'b1;
            n_duty     = 3'd0;
            if (r_len >= LIMIT) begin
                n_len = LC_W'(i_cfg.duty_and_length[5:0]);
            end
            n_shadow   = i_cfg.initial_period;
            n_pcnt     = {1'b0, i_cfg.initial_period};
            n_vol      = i_cfg.envelope_setting[7:4];
            n_env_up   = i_cfg.envelope_setting[3];
            n_env_pace = i_cfg.envelope_setting[2:0];
            n_env_cnt  = 3'd0;
            n_sw_cnt   = 3'd0;
            n_sw_pace  = i_cfg.sweep_setting[6:4];
            n_sw_sub   = i_cfg.sweep_setting[3];
            n_sw_shift = i_cfg.sweep_setting[2:0];
            n_phase    = 2'd0;
            if (i_cfg.sweep_setting[2:0] != 3'd0 && !i_cfg.sweep_setting[3]
                    && start_sum[PERIOD_W]) begin
                n_active = 1'b0;
            end
        end

        if (!i_cfg.master_enable) begin
            n_active = 1'b0;
        end

        run     = i_cfg.master_enable & dac_on & n_active;
        sw_diff = n_shadow >> n_sw_shift;
        sw_sum  = {1'b0, n_shadow} + {1'b0, sw_diff};
        level   = 4'd0;

        if (run) begin
            if (tap_fall) begin
                // length
                if (!n_frame[0] && i_cfg.length_enable) begin
                    if (n_len <= LIMIT) begin
                        n_len = n_len + 1'b1;
                    end
                    if (n_len > LIMIT) begin
                        n_active = 1'b0;
                    end
                end
                // envelope
                if (n_frame == 3'd0 && n_env_pace != 3'd0) begin
                    n_env_cnt = n_env_cnt + 3'd1;
                    if (n_env_cnt >= n_env_pace) begin
                        if (!n_env_up && n_vol != 4'd0) begin
                            n_vol = n_vol - 4'd1;
                        end
                        if (n_env_up && n_vol != 4'd15) begin
                            n_vol = n_vol + 4'd1;
                        end
                        n_env_cnt = 3'd0;
                    end
                end
                // sweep, gated by the live pace bits
                if (n_frame[1:0] == 2'd0 && i_cfg.sweep_setting[6:4] != 3'd0) begin
                    n_sw_cnt = n_sw_cnt + 3'd1;
                    if (n_sw_cnt >= n_sw_pace) begin
                        if (!n_sw_sub) begin
                            if (sw_sum[PERIOD_W]) begin
                                n_active = 1'b0;
                            end else begin
                                n_shadow = sw_sum[PERIOD_W-1:0];
                            end
                        end else begin
                            n_shadow = (sw_diff >= n_shadow) ? '0 : n_shadow - sw_diff;
                        end
                        n_sw_cnt = 3'd0;
                    end
                end
            end
            if (n_phase == 2'd0) begin
                pc_inc = n_pcnt + 1'b1;
                if (pc_inc > {1'b0, PERIOD_MAX}) begin
                    n_pcnt = {1'b0, n_shadow};
                    n_duty = n_duty + 3'd1;
                end else begin
                    n_pcnt = pc_inc;
                end
            end else begin
                pc_inc = n_pcnt;
            end
            if (DUTY_PATTERN[i_cfg.duty_and_length[7:6]][n_duty]) begin
                level = n_vol;
            end
        end else begin
            pc_inc = n_pcnt;
        end

        n_phase = n_phase + 2'd1;

        o_result.level          = level;
        o_result.channel_active = n_active;
        o_result.current_period = n_shadow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tap <= 1'b0;
            r_frame    <= '0;
            r_active   <= 1'b0;
            r_len      <= '0;
            r_vol      <= '0;
            r_env_up   <= 1'b0;
            r_env_pace <= '0;
            r_env_cnt  <= '0;
            r_sw_pace  <= '0;
            r_sw_sub   <= 1'b0;
            r_sw_shift <= '0;
            r_sw_cnt   <= '0;
            r_shadow   <= '0;
            r_pcnt     <= '0;
            r_duty     <= '0;
            r_phase    <= '0;
        end else if (i_step) begin
            r_prev_tap <= n_prev_tap;
            r_frame    <= n_frame;
            r_active   <= n_active;
            r_len      <= n_len;
            r_vol      <= n_vol;
            r_env_up   <= n_env_up;
            r_env_pace <= n_env_pace;
            r_env_cnt  <= n_env_cnt;
            r_sw_pace  <= n_sw_pace;
            r_sw_sub   <= n_sw_sub;
            r_sw_shift <= n_sw_shift;
            r_sw_cnt   <= n_sw_cnt;
            r_shadow   <= n_shadow;
            r_pcnt     <= n_pcnt;
            r_duty     <= n_duty;
            r_phase    <= n_phase;
        end
    end

endmodule

/* hdl/square_wave_channel_with_sweep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_channel_with_sweep
// Square-wave sound channel with length counter, volume envelope and
// period sweep, stepped once per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one word per machine
//   cycle, carrying the divider tap bit and the trigger flag. Each accepted
//   word advances the channel by one cycle and yields exactly one output word.
//   Output channel (o_out_valid / i_out_stall / o_out_data): level, active
//   status and current shadow period.
//   The output word is registered on the edge that accepts the input word.
//   Throughput is one word per cycle unless the receiver stalls; a word is
//   accepted while the previous result is being taken.
//   When the receiver stalls, the held output word stays put and o_in_stall
//   rises, so at most one result waits. The single output register sets this.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; user must write only while the channel is idle (unenforced).
//   Reset clears all channel state, all settings and the output register.
// ----------------------------------------------------------------------------
module square_wave_channel_with_sweep import sqw_pkg::*; #(
    parameter int unsigned LENGTH_LIMIT = DEF_LENGTH_LIMIT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word result;
    logic      accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sqw_core #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_word   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWEEP:    r_cfg.sweep_setting    <= i_cfg_data[6:0];
                CFG_DUTY_LEN: r_cfg.duty_and_length  <= i_cfg_data[7:0];
                CFG_ENVELOPE: r_cfg.envelope_setting <= i_cfg_data[7:0];
                CFG_PERIOD:   r_cfg.initial_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_LEN_EN:   r_cfg.length_enable    <= i_cfg_data[0];
                CFG_MASTER:   r_cfg.master_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
            r_out       <= result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* verif/square_wave_channel_with_sweep_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_channel_with_sweep_tb
// Self-checking bench for the square-wave channel. A queue-fed driver sends
// tap/trigger words under random gaps. A behavioral channel model predicts
// each output word, and a monitor under random back-pressure compares level,
// active status and period field by field. Runs cover several register
// settings, with a long well-formed run that lets the length counter expire.
// ----------------------------------------------------------------------------
module square_wave_channel_with_sweep_tb;
    import sqw_pkg::*;

    localparam int unsigned LEN_LIMIT     = DEF_LENGTH_LIMIT;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HANG_LIMIT    = 500;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // channel model state
    t_cfg        chan_cfg   = '0;
    logic        tap_seen   = 1'b0;
    logic [2:0]  frame_no   = '0;
    logic        playing    = 1'b0;
    int unsigned len_count  = 0;
    logic [3:0]  vol        = '0;
    logic        env_rise   = 1'b0;
    logic [2:0]  env_rate   = '0;
    logic [2:0]  env_tick   = '0;
    logic [2:0]  swp_rate   = '0;
    logic        swp_down   = 1'b0;
    logic [2:0]  swp_shift  = '0;
    logic [2:0]  swp_tick   = '0;
    logic [10:0] shadow     = '0;
    logic [11:0] per_count  = '0;
    logic [2:0]  duty_pos   = '0;
    logic [1:0]  cyc_phase  = '0;

    t_in_word    pending_ticks[$];
    t_out_word   exp_outputs[$];
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    logic        tap_level    = 1'b0;

    square_wave_channel_with_sweep #(
        .LENGTH_LIMIT(LEN_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic predict_channel_output(input t_in_word w, output t_out_word r);
        logic        falling;
        logic        conv_on;
        logic [3:0]  lvl;
        logic [10:0] delta;
        logic [11:0] grown;
        logic [7:0]  wave;
        falling = tap_seen && !w.div_tap_bit;
        if (falling) begin
            frame_no = frame_no + 3'd1;
        end
        tap_seen = w.div_tap_bit;
        conv_on  = (chan_cfg.envelope_setting[7:3] != 5'd0);
        lvl      = 4'd0;
        if (!conv_on) begin
            playing = 1'b0;
        end
        if (w.trigger && conv_on && chan_cfg.master_enable) begin
            playing  = 1'b1;
            duty_pos = 3'd0;
            if (len_count >= LEN_LIMIT) begin
                len_count = chan_cfg.duty_and_length[5:0];
            end
            shadow    = chan_cfg.initial_period;
            per_count = {1'b0, shadow};
            vol       = chan_cfg.envelope_setting[7:4];
            env_rise  = chan_cfg.envelope_setting[3];
            env_rate  = chan_cfg.envelope_setting[2:0];
            env_tick  = 3'd0;
            swp_tick  = 3'd0;
            swp_rate  = chan_cfg.sweep_setting[6:4];
            swp_down  = chan_cfg.sweep_setting[3];
            swp_shift = chan_cfg.sweep_setting[2:0];
            grown     = {1'b0, shadow} + {1'b0, shadow >> swp_shift};
            if (swp_shift != 3'd0 && !swp_down && grown > 12'h7FF) begin
                playing = 1'b0;
            end
            cyc_phase = 2'd0;
        end
        if (!chan_cfg.master_enable) begin
            playing = 1'b0;
        end
        if (chan_cfg.master_enable && conv_on && playing) begin
            if (falling) begin
                if (!frame_no[0] && chan_cfg.length_enable) begin
                    if (len_count <= LEN_LIMIT) begin
                        len_count++;
                    end
                    if (len_count > LEN_LIMIT) begin
                        playing = 1'b0;
                    end
                end
                if (frame_no == 3'd0 && env_rate != 3'd0) begin
                    env_tick = env_tick + 3'd1;
                    if (env_tick >= env_rate) begin
                        if (!env_rise && vol != 4'd0) begin
                            vol = vol - 4'd1;
                        end
                        if (env_rise && vol != 4'd15) begin
                            vol = vol + 4'd1;
                        end
                        env_tick = 3'd0;
                    end
                end
                if (frame_no[1:0] == 2'd0 && chan_cfg.sweep_setting[6:4] != 3'd0) begin
                    swp_tick = swp_tick + 3'd1;
                    if (swp_tick >= swp_rate) begin
                        delta = shadow >> swp_shift;
                        if (!swp_down) begin
                            grown = {1'b0, shadow} + {1'b0, delta};
                            if (grown > 12'h7FF) begin
                                playing = 1'b0;
                            end else begin
                                shadow = grown[10:0];
                            end
                        end else begin
                            shadow = (delta >= shadow) ? 11'd0 : shadow - delta;
                        end
                        swp_tick = 3'd0;
                    end
                end
            end
            if (cyc_phase == 2'd0) begin
                per_count = per_count + 12'd1;
                if (per_count > 12'h7FF) begin
                    per_count = {1'b0, shadow};
                    duty_pos  = duty_pos + 3'd1;
                end
            end
            case (chan_cfg.duty_and_length[7:6])
                2'd0: begin
                    wave = 8'b0111_1111;
                end
                2'd1: begin
                    wave = 8'b0111_1110;
                end
                2'd2: begin
                    wave = 8'b0001_1110;
                end
                default: begin
                    wave = 8'b1000_0001;
                end
            endcase
            if (wave[duty_pos]) begin
                lvl = vol;
            end
        end
        cyc_phase        = cyc_phase + 2'd1;
        r.level          = lvl;
        r.channel_active = playing;
        r.current_period = shadow;
    endtask

    task automatic flag_mismatch(input string what, input t_out_word want,
                                 input t_out_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected level=%0d active=%0d period=%0d", $time, what,
                     want.level, want.channel_active, want.current_period);
            $display("%0t %s:   actual level=%0d active=%0d period=%0d", $time, what,
                     got.level, got.channel_active, got.current_period);
        end
    endtask

    task automatic push_tick(input logic tap, input logic trig);
        t_in_word w;
        w.div_tap_bit = tap;
        w.trigger     = trig;
        pending_ticks.push_back(w);
    endtask

    // well-formed runs open with a trigger; noisy runs are random taps and triggers
    task automatic queue_run(input int count, input int span, input int unsigned trig_pct,
                             input bit noisy);
        logic trig;
        for (int k = 0; k < count; k++) begin
            if (noisy) begin
                tap_level = $urandom_range(1, 0);
                trig      = ($urandom_range(99, 0) < 30);
            end else begin
                if (k % span == 0) begin
                    tap_level = !tap_level;
                end
                trig = (k == 0) || ($urandom_range(99, 0) < trig_pct);
            end
            push_tick(tap_level, trig);
        end
    endtask

    task automatic settle_channel();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || exp_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_SWEEP:    chan_cfg.sweep_setting    = val[6:0];
            CFG_DUTY_LEN: chan_cfg.duty_and_length  = val[7:0];
            CFG_ENVELOPE: chan_cfg.envelope_setting = val[7:0];
            CFG_PERIOD:   chan_cfg.initial_period   = val[10:0];
            CFG_LEN_EN:   chan_cfg.length_enable    = val[0];
            CFG_MASTER:   chan_cfg.master_enable    = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_channel(input logic [6:0] sweep, input logic [7:0] dl,
                                   input logic [7:0] env, input logic [10:0] per,
                                   input logic len_en, input logic master);
        write_reg(CFG_SWEEP,    CFG_DATA_W'(sweep));
        write_reg(CFG_DUTY_LEN, CFG_DATA_W'(dl));
        write_reg(CFG_ENVELOPE, CFG_DATA_W'(env));
        write_reg(CFG_PERIOD,   CFG_DATA_W'(per));
        write_reg(CFG_LEN_EN,   CFG_DATA_W'(len_en));
        write_reg(CFG_MASTER,   CFG_DATA_W'(master));
    endtask

    always @(posedge i_clk) begin : drive_ticks
        logic      nxt_valid;
        t_in_word  nxt_data;
        t_out_word want;
        if (!i_rst_n) begin
            chan_cfg   = '0;
            tap_seen   = 1'b0;
            frame_no   = '0;
            playing    = 1'b0;
            len_count  = 0;
            vol        = '0;
            env_rise   = 1'b0;
            env_rate   = '0;
            env_tick   = '0;
            swp_rate   = '0;
            swp_down   = 1'b0;
            swp_shift  = '0;
            swp_tick   = '0;
            shadow     = '0;
            per_count  = '0;
            duty_pos   = '0;
            cyc_phase  = '0;
            gap_left   = 0;
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_data  = i_in_data;
            if (i_in_valid && !o_in_stall) begin
                predict_channel_output(i_in_data, want);
                exp_outputs.push_back(want);
                nxt_valid = 1'b0;
                if ($urandom_range(99, 0) < gap_pct) begin
                    gap_left = $urandom_range(12, 1);
                end
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ticks.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = pending_ticks.pop_front();
                end
            end
            i_in_valid <= nxt_valid;
            i_in_data  <= nxt_data;
        end
    end

    always @(posedge i_clk) begin : check_outputs
        t_out_word want;
        logic      nxt_stall;
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (exp_outputs.size() == 0) begin
                    flag_mismatch("unexpected word", '0, o_out_data);
                end else begin
                    want = exp_outputs.pop_front();
                    if (o_out_data.level !== want.level ||
                        o_out_data.channel_active !== want.channel_active ||
                        o_out_data.current_period !== want.current_period) begin
                        flag_mismatch("output mismatch", want, o_out_data);
                    end
                end
            end
            nxt_stall = 1'b0;
            if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if ($urandom_range(99, 0) < stall_pct) begin
                stall_left = $urandom_range(11, 0);
                nxt_stall  = 1'b1;
            end
            i_out_stall <= nxt_stall;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [6:0]  sweep;
        logic [7:0]  dl;
        logic [7:0]  env;
        logic [10:0] per;
        logic        len_en;
        logic        master;
        int          n;
        int          span;
        bit          noisy;
        int          random_sent;
        bit          first_run;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // powered down: triggers and tap edges do nothing
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        settle_channel();
        // max period with add sweep: overflow at trigger
        program_channel(7'h01, 8'hFF, 8'hF0, 11'h7FF, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        settle_channel();
        // subtract with zero shift underflows, envelope rises from zero
        program_channel(7'h18, 8'h80, 8'h09, 11'h7FE, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        for (int k = 0; k < 5; k++) begin
            push_tick(1'b0, 1'b0);
            push_tick(1'b1, 1'b0);
        end
        settle_channel();
        // converter off
        program_channel(7'h00, 8'h3F, 8'h07, 11'h000, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        settle_channel();
        program_channel(7'h7F, 8'h40, 8'hFF, 11'h000, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        settle_channel();
        // power removed while playing
        program_channel(7'h7F, 8'h40, 8'hFF, 11'h000, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);

        random_sent = 0;
        first_run   = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            settle_channel();
            sweep  = 7'($urandom);
            dl     = 8'($urandom);
            env    = 8'($urandom);
            per    = ($urandom_range(3, 0) == 0) ? 11'($urandom) : 11'($urandom_range(2047, 1900));
            len_en = ($urandom_range(3, 0) != 0);
            master = ($urandom_range(9, 0) != 0);
            if ($urandom_range(9, 0) == 0) begin
                sweep = ($urandom_range(1, 0) == 1) ? 7'h7F : 7'h00;
            end
            if ($urandom_range(11, 0) == 0) begin
                env[7:3] = 5'd0;
            end
            if ($urandom_range(15, 0) == 0) begin
                per = ($urandom_range(1, 0) == 1) ? 11'h7FF : 11'h000;
            end
            if (first_run) begin
                // long steady run so the length counter runs out
                sweep[6:3] = 4'b0001;
                env[7:4]   = 4'hF;
                len_en     = 1'b1;
                master     = 1'b1;
                n          = 280;
                span       = 1;
                noisy      = 1'b0;
            end else begin
                n     = $urandom_range(110, 40);
                span  = $urandom_range(3, 1);
                noisy = ($urandom_range(5, 0) == 0);
            end
            case ($urandom_range(2, 0))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(2, 0))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
            program_channel(sweep, dl, env, per, len_en, master);
            queue_run(n, span, $urandom_range(5, 1), noisy);
            random_sent += n;
            first_run    = 1'b0;
        end

        settle_channel();
        gap_pct   = 0;
        stall_pct = 0;
        program_channel(7'h2C, 8'hA0, 8'hA1, 11'h7F0, 1'b1, 1'b1);
        queue_run(40, 1, 3, 1'b0);
        settle_channel();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
